FILE: sv/assert_macros.svh
// assertion macros used by the checker file bsb_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on the rising clock, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// concurrent assertion that stays armed through reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: sv/bsb_pkg.sv
// types and constants of the boid steering blend
// used by the controller, the datapath and the top level
package bsb_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned VEC_W   = 42;
  localparam int unsigned MAG_W   = 41;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned RAD_W   = 31;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned UNIT_W  = 18;
  localparam int unsigned QUO_W   = 17;
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned ACC_W   = 68;
  localparam int unsigned OPND_W  = 34;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned IN_W    = 6 * COORD_W;
  localparam int unsigned OUT_W   = 3 * COORD_W;

  localparam logic [STEP_W-1:0] SQRT_FIRST = STEP_W'(31);
  localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(QUO_W - 1);
  localparam logic [STEP_W-1:0] TERM_LAST  = STEP_W'(3);
  localparam logic [1:0]        AXIS_LAST  = 2'd2;

  localparam logic [1:0] VEC_COH = 2'd0;
  localparam logic [1:0] VEC_ALI = 2'd1;
  localparam logic [1:0] VEC_SEP = 2'd2;

  localparam logic [1:0] TERM_DIR = 2'd0;
  localparam logic [1:0] TERM_COH = 2'd1;
  localparam logic [1:0] TERM_ALI = 2'd2;
  localparam logic [1:0] TERM_SEP = 2'd3;

  localparam logic [CIDX_W-1:0] REG_WDIR = 3'd0;
  localparam logic [CIDX_W-1:0] REG_WALI = 3'd1;
  localparam logic [CIDX_W-1:0] REG_WCOH = 3'd2;
  localparam logic [CIDX_W-1:0] REG_WSEP = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SEPR = 3'd4;

  localparam logic CMD_START = 1'b0;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_OVF, OP_NEIGH, OP_RSQ, OP_DSQ, OP_NEAR,
    OP_LOAD, OP_NORM, OP_UZERO, OP_MSQ, OP_SQINIT, OP_SQRT,
    OP_DINIT, OP_DIV, OP_DSTORE, OP_BLEND, OP_BROUND, OP_PASS, OP_FOUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        axis;
    logic [1:0]        vsel;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic few;
    logic zero;
    logic norm_ok;
    logic out_busy;
  } stat_t;

endpackage

FILE: sv/bsb_datapath.sv
// datapath: sums, near test, shared multiplier, shift normalizer,
// bit-serial root and divider, blend and output register; uses bsb_pkg
module bsb_datapath #(
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bsb_pkg::cmd_t                 cmd,
  output bsb_pkg::stat_t                stat,
  input  logic                          in_accept,
  input  logic [bsb_pkg::IN_W-1:0]      in_data,
  input  logic                          cfg_we,
  input  logic [bsb_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [bsb_pkg::RAD_W-1:0]     cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [bsb_pkg::OUT_W-1:0]     out_data,
  output logic [1:0]                    out_user
);
  import bsb_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NEIGHBORS);

  logic [WGT_W-1:0] w_dir, w_ali, w_coh, w_sep;
  logic [RAD_W-1:0] sep_radius;

  logic signed [COORD_W-1:0] own [3];
  logic signed [COORD_W-1:0] dd  [3];
  logic signed [COORD_W-1:0] hp  [3];
  logic signed [COORD_W-1:0] hv  [3];
  logic signed [SUM_W-1:0]   psum [3];
  logic signed [SUM_W-1:0]   vsum [3];
  logic signed [SUM_W-1:0]   osum [3];
  logic [CNT_W-1:0]          ncount;
  logic                      ovf;
  logic signed [COORD_W:0]   off [3];
  logic signed [COORD_W:0]   off_new [3];
  logic                      near_ok;
  logic                      near_ok_new;
  logic [2*RAD_W-1:0]        r2;
  logic signed [ACC_W-1:0]   acc;
  logic [MAG_W-1:0]          m [3];
  logic                      sgn [3];
  logic [MAG_W-1:0]          top;
  logic [63:0]               sq_n, sq_r, sq_bit, sq_try;
  logic [LEN_W-1:0]          rem;
  logic [QUO_W-1:0]          dl, quo;
  logic [LEN_W:0]            dtry;
  logic signed [UNIT_W-1:0]  u [3][3];
  logic signed [COORD_W-1:0] res [3];
  logic signed [COORD_W-1:0] out_dir [3];
  logic                      out_blend, out_ovf;

  logic signed [OPND_W-1:0]  mul_a, mul_b;
  logic signed [ACC_W-1:0]   prod;
  logic [COORD_W:0]          offmag;
  logic signed [VEC_W-1:0]   wv;
  logic signed [ACC_W-1:0]   rnd;
  logic [3*COORD_W-1:0]      unused_res;

  always_comb begin
    near_ok_new = 1'b1;
    for (int i = 0; i < 3; i++) begin
      off_new[i] = {own[i][COORD_W-1], own[i]} - {hp[i][COORD_W-1], hp[i]};
      if (!(off_new[i][COORD_W:COORD_W-1] == 2'b00 ||
            (off_new[i][COORD_W:COORD_W-1] == 2'b11 && off_new[i][COORD_W-2:0] != '0)))
        near_ok_new = 1'b0;
    end
  end

  assign offmag = off[cmd.axis][COORD_W] ? (COORD_W+1)'(0) - off[cmd.axis] : off[cmd.axis];

  always_comb begin
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_RSQ: begin
        mul_a = {3'b000, sep_radius};
        mul_b = {3'b000, sep_radius};
      end
      OP_DSQ: begin
        mul_a = {1'b0, offmag};
        mul_b = {1'b0, offmag};
      end
      OP_LOAD: begin
        mul_a = {{(OPND_W-CNT_W){1'b0}}, ncount};
        mul_b = {{2{own[cmd.axis][COORD_W-1]}}, own[cmd.axis]};
      end
      OP_MSQ: begin
        mul_a = {4'b0000, m[cmd.axis][29:0]};
        mul_b = {4'b0000, m[cmd.axis][29:0]};
      end
      OP_BLEND: begin
        case (cmd.step[1:0])
          TERM_DIR: begin
            mul_a = {{(OPND_W-WGT_W){1'b0}}, w_dir};
            mul_b = {{2{dd[cmd.axis][COORD_W-1]}}, dd[cmd.axis]};
          end
          TERM_COH: begin
            mul_a = {{(OPND_W-WGT_W){1'b0}}, w_coh};
            mul_b = {{(OPND_W-UNIT_W){u[VEC_COH][cmd.axis][UNIT_W-1]}},
                     u[VEC_COH][cmd.axis]};
          end
          TERM_ALI: begin
            mul_a = {{(OPND_W-WGT_W){1'b0}}, w_ali};
            mul_b = {{(OPND_W-UNIT_W){u[VEC_ALI][cmd.axis][UNIT_W-1]}},
                     u[VEC_ALI][cmd.axis]};
          end
          default: begin
            mul_a = {{(OPND_W-WGT_W){1'b0}}, w_sep};
            mul_b = {{(OPND_W-UNIT_W){u[VEC_SEP][cmd.axis][UNIT_W-1]}},
                     u[VEC_SEP][cmd.axis]};
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (cmd.vsel)
      VEC_COH: wv = {{(VEC_W-SUM_W){psum[cmd.axis][SUM_W-1]}}, psum[cmd.axis]}
                    - prod[VEC_W-1:0];
      VEC_SEP: wv = {{(VEC_W-SUM_W){osum[cmd.axis][SUM_W-1]}}, osum[cmd.axis]};
      default: wv = {{(VEC_W-SUM_W){vsum[cmd.axis][SUM_W-1]}}, vsum[cmd.axis]};
    endcase
  end

  assign sq_bit = 64'(1) << {cmd.step, 1'b0};
  assign sq_try = sq_r + sq_bit;
  assign dtry   = {rem, dl[QUO_W-1]};
  assign rnd    = (acc + ACC_W'(2048)) >>> 12;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_dir      <= WGT_W'(3277);
      w_ali      <= WGT_W'(4506);
      w_coh      <= WGT_W'(2458);
      w_sep      <= WGT_W'(8192);
      sep_radius <= RAD_W'(983040);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WDIR: w_dir      <= cfg_data[WGT_W-1:0];
        REG_WALI: w_ali      <= cfg_data[WGT_W-1:0];
        REG_WCOH: w_coh      <= cfg_data[WGT_W-1:0];
        REG_WSEP: w_sep      <= cfg_data[WGT_W-1:0];
        REG_SEPR: sep_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < 3; i++) begin
        hp[i] <= in_data[COORD_W*i +: COORD_W];
        hv[i] <= in_data[COORD_W*(3+i) +: COORD_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        own[i]  <= '0;
        dd[i]   <= '0;
        psum[i] <= '0;
        vsum[i] <= '0;
        osum[i] <= '0;
      end
      ncount <= '0;
      ovf    <= 1'b0;
    end else begin
      case (cmd.op)
        OP_START: begin
          for (int i = 0; i < 3; i++) begin
            own[i]  <= hp[i];
            dd[i]   <= hv[i];
            psum[i] <= '0;
            vsum[i] <= '0;
            osum[i] <= '0;
          end
          ncount <= '0;
          ovf    <= 1'b0;
        end
        OP_OVF: ovf <= 1'b1;
        OP_NEIGH: begin
          for (int i = 0; i < 3; i++) begin
            psum[i] <= psum[i] + {{(SUM_W-COORD_W){hp[i][COORD_W-1]}}, hp[i]};
            vsum[i] <= vsum[i] + {{(SUM_W-COORD_W){hv[i][COORD_W-1]}}, hv[i]};
          end
          ncount <= ncount + 1'b1;
        end
        OP_NEAR: begin
          if (near_ok && acc < $signed({6'b0, r2})) begin
            for (int i = 0; i < 3; i++)
              osum[i] <= osum[i] + {{(SUM_W-COORD_W-1){off[i][COORD_W]}}, off[i]};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_NEIGH: begin
        for (int i = 0; i < 3; i++) off[i] <= off_new[i];
        near_ok <= near_ok_new;
      end
      OP_RSQ: r2 <= prod[2*RAD_W-1:0];
      OP_DSQ, OP_MSQ: acc <= (cmd.axis == 2'd0 ? ACC_W'(0) : acc) + prod;
      OP_BLEND: acc <= (cmd.step[1:0] == TERM_DIR ? ACC_W'(0) : acc) + prod;
      OP_LOAD: begin
        m[cmd.axis]   <= wv[VEC_W-1] ? MAG_W'(-wv) : wv[MAG_W-1:0];
        sgn[cmd.axis] <= wv[VEC_W-1];
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++)
          m[i] <= top[MAG_W-1:30] != '0 ? m[i] >> 1 : m[i] << 1;
      end
      OP_SQINIT: begin
        sq_n <= acc[63:0];
        sq_r <= '0;
      end
      OP_SQRT: begin
        if (sq_n >= sq_try) begin
          sq_n <= sq_n - sq_try;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
      end
      OP_DINIT: begin
        rem <= {2'b00, m[cmd.axis][29:1]};
        dl  <= {m[cmd.axis][0], 16'b0};
        quo <= '0;
      end
      OP_DIV: begin
        if (dtry >= {1'b0, sq_r[LEN_W-1:0]}) begin
          rem <= LEN_W'(dtry - {1'b0, sq_r[LEN_W-1:0]});
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= dtry[LEN_W-1:0];
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        dl <= dl << 1;
      end
      OP_DSTORE: u[cmd.vsel][cmd.axis] <= sgn[cmd.axis] ? -$signed({1'b0, quo})
                                                        : $signed({1'b0, quo});
      OP_UZERO: for (int i = 0; i < 3; i++) u[cmd.vsel][i] <= '0;
      OP_BROUND: begin
        if (rnd[ACC_W-1:COORD_W-1] == '0 || rnd[ACC_W-1:COORD_W-1] == '1)
          res[cmd.axis] <= rnd[COORD_W-1:0];
        else
          res[cmd.axis] <= rnd[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                        : {1'b0, {(COORD_W-1){1'b1}}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_PASS || cmd.op == OP_FOUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PASS) begin
      for (int i = 0; i < 3; i++) out_dir[i] <= dd[i];
      out_blend <= 1'b0;
      out_ovf   <= ovf;
    end else if (cmd.op == OP_FOUT) begin
      for (int i = 0; i < 3; i++) out_dir[i] <= res[i];
      out_blend <= 1'b1;
      out_ovf   <= ovf;
    end
  end

  assign unused_res = '0;
  assign out_data   = {out_dir[2], out_dir[1], out_dir[0]} | unused_res;
  assign out_user   = {out_ovf, out_blend};

  assign stat.full     = ncount >= CNT_MAX;
  assign stat.few      = ncount <= CNT_W'(1);
  assign stat.zero     = top == '0;
  assign stat.norm_ok  = top[MAG_W-1:29] == (MAG_W-29)'(1);
  assign stat.out_busy = out_valid & ~out_ready;

endmodule

FILE: sv/bsb_ctrl.sv
// controller state machine: sequences the datapath per item and per result
// uses bsb_pkg command and status types
module bsb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_user,
  input  logic           in_last,
  input  bsb_pkg::stat_t stat,
  output bsb_pkg::cmd_t  cmd
);
  import bsb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ITEM, S_RSQ, S_DSQ, S_NEAR, S_FIN, S_LOAD, S_NORM, S_MSQ,
    S_SQINIT, S_SQRT, S_DINIT, S_DIV, S_DSTORE, S_BLEND, S_BROUND, S_OUT
  } state_t;

  state_t            state;
  logic [1:0]        axis;
  logic [1:0]        vsel;
  logic [STEP_W-1:0] step;
  logic              kind;
  logic              last;
  logic              pass;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
      vsel  <= '0;
      step  <= '0;
      kind  <= 1'b0;
      last  <= 1'b0;
      pass  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind  <= in_user;
            last  <= in_last;
            state <= S_ITEM;
          end
        end
        S_ITEM: state <= (kind != CMD_START && !stat.full) ? S_RSQ : S_FIN;
        S_RSQ: begin
          axis  <= '0;
          state <= S_DSQ;
        end
        S_DSQ: begin
          axis <= axis + 1'b1;
          if (axis == AXIS_LAST) state <= S_NEAR;
        end
        S_NEAR: state <= S_FIN;
        S_FIN: begin
          axis <= '0;
          vsel <= VEC_COH;
          if (!last) begin
            state <= S_IDLE;
          end else if (stat.few) begin
            pass  <= 1'b1;
            state <= S_OUT;
          end else begin
            pass  <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          axis <= axis + 1'b1;
          if (axis == AXIS_LAST) state <= S_NORM;
        end
        S_NORM: begin
          axis <= '0;
          if (stat.zero) begin
            step <= '0;
            if (vsel == VEC_SEP) begin
              state <= S_BLEND;
            end else begin
              vsel  <= vsel + 1'b1;
              state <= S_LOAD;
            end
          end else if (stat.norm_ok) begin
            state <= S_MSQ;
          end
        end
        S_MSQ: begin
          axis <= axis + 1'b1;
          if (axis == AXIS_LAST) state <= S_SQINIT;
        end
        S_SQINIT: begin
          axis  <= '0;
          step  <= SQRT_FIRST;
          state <= S_SQRT;
        end
        S_SQRT: begin
          step <= step - 1'b1;
          if (step == '0) state <= S_DINIT;
        end
        S_DINIT: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == DIV_LAST) state <= S_DSTORE;
        end
        S_DSTORE: begin
          step <= '0;
          if (axis != AXIS_LAST) begin
            axis  <= axis + 1'b1;
            state <= S_DINIT;
          end else begin
            axis <= '0;
            if (vsel == VEC_SEP) begin
              state <= S_BLEND;
            end else begin
              vsel  <= vsel + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_BLEND: begin
          step <= step + 1'b1;
          if (step == TERM_LAST) state <= S_BROUND;
        end
        S_BROUND: begin
          step <= '0;
          if (axis == AXIS_LAST) begin
            state <= S_OUT;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_BLEND;
          end
        end
        S_OUT: if (!stat.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.axis = axis;
    cmd.vsel = vsel;
    cmd.step = step;
    case (state)
      S_ITEM: begin
        if (kind == CMD_START) cmd.op = OP_START;
        else if (stat.full)    cmd.op = OP_OVF;
        else                   cmd.op = OP_NEIGH;
      end
      S_RSQ:    cmd.op = OP_RSQ;
      S_DSQ:    cmd.op = OP_DSQ;
      S_NEAR:   cmd.op = OP_NEAR;
      S_LOAD:   cmd.op = OP_LOAD;
      S_NORM: begin
        if (stat.zero)         cmd.op = OP_UZERO;
        else if (stat.norm_ok) cmd.op = OP_NONE;
        else                   cmd.op = OP_NORM;
      end
      S_MSQ:    cmd.op = OP_MSQ;
      S_SQINIT: cmd.op = OP_SQINIT;
      S_SQRT:   cmd.op = OP_SQRT;
      S_DINIT:  cmd.op = OP_DINIT;
      S_DIV:    cmd.op = OP_DIV;
      S_DSTORE: cmd.op = OP_DSTORE;
      S_BLEND:  cmd.op = OP_BLEND;
      S_BROUND: cmd.op = OP_BROUND;
      S_OUT: begin
        if (stat.out_busy) cmd.op = OP_NONE;
        else if (pass)     cmd.op = OP_PASS;
        else               cmd.op = OP_FOUT;
      end
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: sv/boid_steering_blend.sv
// top level of the boid steering blend: stream ports, config port
// instantiates bsb_ctrl and bsb_datapath, uses bsb_pkg
//
// A group is a start transaction (tuser 0) with own position and desired
// direction, then neighbour transactions (tuser 1); tlast on any of them
// emits one result. One transaction is taken at a time. A kept neighbour,
// unlike a start or a dropped one, also squares the radius and each offset
// (one pass of the shared multiplier per square) before the near test. A
// last transaction with two or more neighbours then, for each of the three
// flock vectors, loads each axis, applies one-bit normalizing shifts, squares
// each axis, runs the bit-serial root and, per axis, the bit-serial divider
// (a zero vector skips both), and finally blends each axis. The result
// register lets the next transaction in while a result waits.
module boid_steering_blend #(
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // pos_x, pos_y, pos_z, vec_x, vec_y, vec_z
  input  logic [bsb_pkg::IN_W-1:0]   s_axis_tdata,
  // cmd
  input  logic                       s_axis_tuser,
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // dir_x, dir_y, dir_z
  output logic [bsb_pkg::OUT_W-1:0]  m_axis_tdata,
  // blended, overflow
  output logic [1:0]                 m_axis_tuser,
  input  logic                       cfg_we,
  input  logic [bsb_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bsb_pkg::RAD_W-1:0]  cfg_data
);
  import bsb_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_accept;

  assign in_accept = s_axis_tvalid & s_axis_tready;

  bsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_user  (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsb_datapath #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_accept (in_accept),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

FILE: sv/bsb_checker.sv
// port-level checks of the boid steering blend, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module bsb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a result waits until it is taken
  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // a stalled result keeps its payload
  `ASSERT_CLK(a_out_stable, clk, rst,
              m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // one transaction at a time: no input right after an accepted one
  `ASSERT_CLK(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // reset leaves no result pending
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid)

endmodule

bind boid_steering_blend bsb_checker u_bsb_checker (.*);
